/* rtl/core/ffha_pkg.sv */
`timescale 1ns / 1ps
package ffha_pkg;

  localparam int ADDR_W = 48;
  localparam int SIZE_W = 32;
  localparam int NEED_W = 33;
  localparam int SPLT_W = 34;
  localparam int STAT_W = 3;

  localparam logic [3:0] ALIGN_MASK  = 4'd15;
  localparam logic [4:0] MIN_PAYLOAD = 5'd16;

  // request codes
  localparam logic FUNC_ALLOC   = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

  // configuration register indexes
  localparam logic CFG_HEAP_BASE  = 1'b0;
  localparam logic CFG_HEAP_LIMIT = 1'b1;

  localparam logic [SIZE_W-1:0] HEAP_LIMIT_RST = 32'd1048576;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 3'd0,
    ST_ZERO_SIZE = 3'd1,
    ST_EXHAUSTED = 3'd2,
    ST_TBL_FULL  = 3'd3,
    ST_UNKNOWN   = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALLOC_SCAN,
    S_ALLOC_SPLIT,
    S_ALLOC_END,
    S_REL_FIND,
    S_REL_MERGE,
    S_DONE
  } fsm_t;

  // one heap segment
  typedef struct packed {
    logic [SIZE_W-1:0] size;
    logic              free;
  } seg_t;

  // shift and write control shared by every cell of the row
  typedef struct packed {
    logic pop;
    logic push;
    seg_t data;
  } chain_ctl_t;

endpackage

/* rtl/core/ffha_if.sv */
`timescale 1ns / 1ps
interface ffha_in_if;
  import ffha_pkg::*;
  logic              valid;
  logic              ready;
  logic              func;
  logic [SIZE_W-1:0] req_size;
  logic [ADDR_W-1:0] release_addr;
  modport source (output valid, func, req_size, release_addr, input ready);
  modport sink (input valid, func, req_size, release_addr, output ready);
endinterface

interface ffha_out_if;
  import ffha_pkg::*;
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] addr;
  logic [STAT_W-1:0] status;
  modport source (output valid, addr, status, input ready);
  modport sink (input valid, addr, status, output ready);
endinterface

/* rtl/core/first_fit_heap_allocator_top.sv */
`timescale 1ns / 1ps
// channel   dir  handshake        word
// in_ch     in   valid / ready    func, req_size, release_addr
// out_ch    out  valid / ready    addr, status
// cfg_*     in   cfg_we           cfg_idx, cfg_wdata
//
// allocate: the row of cells rotates past the head one table entry at a time,
// with an extra split step, and setup, end and result steps around the scan.
// release: two passes over the row (find, then mark and merge).
// reset is synchronous; the table comes up empty with no clearing pass.
// a waiting result does not block the next request from being taken.
module first_fit_heap_allocator_top #(
  parameter int MAX_SEGMENTS = 64,
  parameter int HEADER_BYTES = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  ffha_in_if.sink                       in_ch,
  ffha_out_if.source                    out_ch,
  input  logic                          cfg_we,
  input  logic                          cfg_idx,
  input  logic [ffha_pkg::ADDR_W-1:0]   cfg_wdata
);
  import ffha_pkg::*;

  localparam int CW = $clog2(MAX_SEGMENTS + 1);

  fsm_t               state_r, state_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [CW-1:0]      left_r, left_nxt;
  logic [CW-1:0]      pos_r, pos_nxt;
  logic [CW-1:0]      idx_r, idx_nxt;
  logic               found_r, found_nxt;
  logic               hold_v_r, hold_v_nxt;
  logic [SIZE_W-1:0]  top_r, top_nxt;
  logic [ADDR_W-1:0]  base_r;
  logic [SIZE_W-1:0]  limit_r;
  logic               out_v_r, out_v_nxt;

  logic [SIZE_W-1:0]  off_r, off_nxt;
  logic [NEED_W-1:0]  need_r, need_nxt;
  logic [ADDR_W-1:0]  where_r, where_nxt;
  logic [ADDR_W-1:0]  addr_r, addr_nxt;
  status_t            stat_r, stat_nxt;
  seg_t               hold_r, hold_nxt;
  seg_t               rem_r, rem_nxt;
  logic [ADDR_W-1:0]  out_addr_r, out_addr_nxt;
  status_t            out_stat_r, out_stat_nxt;

  chain_ctl_t         ctl;
  logic [CW-1:0]      wr_idx;
  seg_t               cell_q [MAX_SEGMENTS];
  seg_t               right_q [MAX_SEGMENTS];

  seg_t               head, head_mod;
  logic [SIZE_W-1:0]  addr_sel;
  logic [ADDR_W-1:0]  cand_addr;
  logic               fits, split_ok, table_full, no_room;

  // row of cells
  assign wr_idx = cnt_r - CW'(ctl.pop);

  for (genvar i = 0; i < MAX_SEGMENTS; i++) begin : g_cell
    if (i == MAX_SEGMENTS - 1) begin : g_last
      assign right_q[i] = '0;
    end else begin : g_mid
      assign right_q[i] = cell_q[i+1];
    end
    ffha_cell #(.CW(CW), .IDX(i)) u_cell (
      .clk    (clk),
      .ctl    (ctl),
      .wr_idx (wr_idx),
      .right  (right_q[i]),
      .data   (cell_q[i])
    );
  end

  // head entry checks
  assign head      = cell_q[0];
  assign addr_sel  = (state_r == S_ALLOC_END) ? top_r : off_r;
  assign cand_addr = base_r + ADDR_W'(addr_sel) + ADDR_W'(HEADER_BYTES);
  assign fits      = head.free && ({1'b0, head.size} >= need_r);
  assign split_ok  = ({2'b0, head.size} >=
                      ({1'b0, need_r} + SPLT_W'(HEADER_BYTES) + SPLT_W'(MIN_PAYLOAD)))
                     && (cnt_r < CW'(MAX_SEGMENTS));
  assign table_full = (cnt_r >= CW'(MAX_SEGMENTS));
  assign no_room    = (top_r > limit_r) || (need_r > {1'b0, limit_r - top_r});

  assign in_ch.ready   = (state_r == S_IDLE);
  assign out_ch.valid  = out_v_r;
  assign out_ch.addr   = out_addr_r;
  assign out_ch.status = out_stat_r;

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    left_nxt     = left_r;
    pos_nxt      = pos_r;
    idx_nxt      = idx_r;
    found_nxt    = found_r;
    hold_v_nxt   = hold_v_r;
    top_nxt      = top_r;
    off_nxt      = off_r;
    need_nxt     = need_r;
    where_nxt    = where_r;
    addr_nxt     = addr_r;
    stat_nxt     = stat_r;
    hold_nxt     = hold_r;
    rem_nxt      = rem_r;
    out_v_nxt    = out_v_r && !out_ch.ready;
    out_addr_nxt = out_addr_r;
    out_stat_nxt = out_stat_r;
    ctl          = '0;
    head_mod     = head;

    case (state_r)
      S_IDLE: begin
        off_nxt   = '0;
        left_nxt  = cnt_r;
        pos_nxt   = '0;
        found_nxt = 1'b0;
        hold_v_nxt = 1'b0;
        addr_nxt  = '0;
        stat_nxt  = ST_OK;
        need_nxt  = ({1'b0, in_ch.req_size} + NEED_W'(HEADER_BYTES) + NEED_W'(ALIGN_MASK))
                    & ~NEED_W'(ALIGN_MASK);
        where_nxt = in_ch.release_addr;
        if (in_ch.valid) begin
          if (in_ch.func == FUNC_ALLOC) begin
            if (in_ch.req_size == '0) begin
              stat_nxt  = ST_ZERO_SIZE;
              state_nxt = S_DONE;
            end else begin
              state_nxt = S_ALLOC_SCAN;
            end
          end else begin
            state_nxt = (in_ch.release_addr == '0) ? S_DONE : S_REL_FIND;
          end
        end
      end

      S_ALLOC_SCAN: begin
        if (left_r == '0) begin
          state_nxt = S_ALLOC_END;
        end else begin
          ctl.pop  = 1'b1;
          ctl.push = 1'b1;
          ctl.data = head;
          if (!found_r && fits) begin
            found_nxt = 1'b1;
            addr_nxt  = cand_addr;
            if (split_ok) begin
              ctl.data  = '{size: need_r[SIZE_W-1:0], free: 1'b0};
              rem_nxt   = '{size: head.size - need_r[SIZE_W-1:0], free: 1'b1};
              state_nxt = S_ALLOC_SPLIT;
            end else begin
              ctl.data.free = 1'b0;
            end
          end
          off_nxt  = off_r + head.size;
          left_nxt = left_r - CW'(1);
        end
      end

      S_ALLOC_SPLIT: begin
        // remainder goes in behind the granted part
        ctl.push  = 1'b1;
        ctl.data  = rem_r;
        cnt_nxt   = cnt_r + CW'(1);
        state_nxt = S_ALLOC_SCAN;
      end

      S_ALLOC_END: begin
        state_nxt = S_DONE;
        if (!found_r) begin
          if (table_full) begin
            stat_nxt = ST_TBL_FULL;
          end else if (no_room) begin
            stat_nxt = ST_EXHAUSTED;
          end else begin
            ctl.push = 1'b1;
            ctl.data = '{size: need_r[SIZE_W-1:0], free: 1'b0};
            cnt_nxt  = cnt_r + CW'(1);
            addr_nxt = cand_addr;
            top_nxt  = top_r + need_r[SIZE_W-1:0];
          end
        end
      end

      S_REL_FIND: begin
        if (left_r == '0) begin
          left_nxt = cnt_r;
          pos_nxt  = '0;
          if (found_r) begin
            state_nxt = S_REL_MERGE;
          end else begin
            stat_nxt  = ST_UNKNOWN;
            state_nxt = S_DONE;
          end
        end else begin
          // plain rotation, looking for the header match
          ctl.pop  = 1'b1;
          ctl.push = 1'b1;
          ctl.data = head;
          if (!found_r && (cand_addr == where_r)) begin
            found_nxt = 1'b1;
            idx_nxt   = pos_r;
          end
          off_nxt  = off_r + head.size;
          pos_nxt  = pos_r + CW'(1);
          left_nxt = left_r - CW'(1);
        end
      end

      S_REL_MERGE: begin
        if (left_r == '0) begin
          // flush the last held entry
          ctl.push  = hold_v_r;
          ctl.data  = hold_r;
          cnt_nxt   = cnt_r + CW'(hold_v_r);
          state_nxt = S_DONE;
        end else begin
          if (pos_r == idx_r) begin
            head_mod.free = 1'b1;
          end
          ctl.pop = 1'b1;
          if (hold_v_r && hold_r.free && head_mod.free) begin
            hold_nxt.size = hold_r.size + head_mod.size;
            cnt_nxt       = cnt_r - CW'(1);
          end else begin
            ctl.push   = hold_v_r;
            ctl.data   = hold_r;
            hold_nxt   = head_mod;
            hold_v_nxt = 1'b1;
            cnt_nxt    = cnt_r - CW'(1) + CW'(hold_v_r);
          end
          pos_nxt  = pos_r + CW'(1);
          left_nxt = left_r - CW'(1);
        end
      end

      S_DONE: begin
        if (!out_v_r || out_ch.ready) begin
          out_v_nxt    = 1'b1;
          out_addr_nxt = addr_r;
          out_stat_nxt = stat_r;
          state_nxt    = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      left_r   <= '0;
      pos_r    <= '0;
      idx_r    <= '0;
      found_r  <= 1'b0;
      hold_v_r <= 1'b0;
      top_r    <= '0;
      out_v_r  <= 1'b0;
      base_r   <= '0;
      limit_r  <= HEAP_LIMIT_RST;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      left_r   <= left_nxt;
      pos_r    <= pos_nxt;
      idx_r    <= idx_nxt;
      found_r  <= found_nxt;
      hold_v_r <= hold_v_nxt;
      top_r    <= top_nxt;
      out_v_r  <= out_v_nxt;
      if (cfg_we) begin
        case (cfg_idx)
          CFG_HEAP_BASE:  base_r  <= cfg_wdata;
          CFG_HEAP_LIMIT: limit_r <= cfg_wdata[SIZE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    off_r      <= off_nxt;
    need_r     <= need_nxt;
    where_r    <= where_nxt;
    addr_r     <= addr_nxt;
    stat_r     <= stat_nxt;
    hold_r     <= hold_nxt;
    rem_r      <= rem_nxt;
    out_addr_r <= out_addr_nxt;
    out_stat_r <= out_stat_nxt;
  end
endmodule

/* rtl/core/ffha_cell.sv */
`timescale 1ns / 1ps
module ffha_cell #(
  parameter int CW  = 7,
  parameter int IDX = 0
) (
  input  logic                clk,
  input  ffha_pkg::chain_ctl_t ctl,
  input  logic [CW-1:0]       wr_idx,
  input  ffha_pkg::seg_t      right,
  output ffha_pkg::seg_t      data
);
  import ffha_pkg::*;

  seg_t data_r;

  // write at the tail slot, otherwise shift toward the head on pop
  always_ff @(posedge clk) begin
    if (ctl.push && (wr_idx == CW'(IDX))) begin
      data_r <= ctl.data;
    end else if (ctl.pop) begin
      data_r <= right;
    end
  end

  assign data = data_r;
endmodule

/* rtl/core/ffha_checker.sv */
`timescale 1ns / 1ps
module ffha_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [ffha_pkg::ADDR_W-1:0] out_addr,
  input logic [ffha_pkg::STAT_W-1:0] out_status
);
  import ffha_pkg::*;

  // a word held back stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // one request in flight: intake closes after a word is taken
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while busy");

  // failed requests grant nothing
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> (out_addr == '0))
    else $error("address granted with a failure status");

  // status code in range
  a_stat_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status <= ST_UNKNOWN))
    else $error("status code out of range");
endmodule

bind first_fit_heap_allocator_top ffha_checker u_ffha_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_addr   (out_ch.addr),
  .out_status (out_ch.status)
);
